[rtl/fhm_pkg.sv]
`default_nettype none
package fhm_pkg;
  localparam int unsigned FlowsDef     = 256;
  localparam int unsigned MaxBinsDef   = 32;
  localparam int unsigned CountBitsDef = 8;
  localparam int unsigned UsPerMs      = 1000;

  localparam logic [1:0] RegQuantShift   = 2'd0;
  localparam logic [1:0] RegSizeBins     = 2'd1;
  localparam logic [1:0] RegGapBins      = 2'd2;
  localparam logic [1:0] RegMarkerPkts   = 2'd3;

  localparam logic HistLength = 1'b0;
  localparam logic HistGap    = 1'b1;

  typedef struct packed {
    logic [7:0]  slot;
    logic [15:0] len;
    logic [31:0] ts;
  } fhm_req_t;
endpackage
`default_nettype wire

[rtl/flow_histogram_marker_core.sv]
`default_nettype none
// Per packet: a new flow goes straight to the bin update; a gap for a known flow
// is first divided in the reciprocal-multiply divider. A marker drains the flow's
// length bins, then its gap bins, followed by a clearing walk over its MaxBins
// bins. After reset, a clearing pass over all Flows*MaxBins histogram entries
// runs before the first packet is taken.
module flow_histogram_marker_core
  import fhm_pkg::*;
#(
  parameter int unsigned Flows     = FlowsDef,
  parameter int unsigned MaxBins   = MaxBinsDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // flow_slot, packet_length, timestamp_us
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_flow, bin_index, bin_count, zero pad
  output logic             m_axis_tuser,  // hist_kind
  output logic             m_axis_tlast
);
  logic [4:0] qs_q;
  logic [5:0] sb_q, gb_q;
  logic [7:0] mp_q;
  fhm_req_t   in_req, q_req;
  logic       q_valid, q_ready;
  logic [7:0] of;
  logic [4:0] bi;
  logic [7:0] bc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q <= 5'd4;
      sb_q <= 6'd32;
      gb_q <= 6'd32;
      mp_q <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegQuantShift: qs_q <= cfg_data_i[4:0];
        RegSizeBins:   sb_q <= cfg_data_i[5:0];
        RegGapBins:    gb_q <= cfg_data_i[5:0];
        RegMarkerPkts: mp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_req.slot = s_axis_tdata[7:0];
  assign in_req.len  = s_axis_tdata[23:8];
  assign in_req.ts   = s_axis_tdata[55:24];

  fhm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  fhm_back #(.Flows(Flows), .MaxBins(MaxBins), .CountBits(CountBits)) u_back (
    .clk_i, .rst_ni,
    .quant_shift_i    (qs_q),
    .size_bins_i      (sb_q),
    .gap_bins_i       (gb_q),
    .marker_packets_i (mp_q),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_req_i          (q_req),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_flow_o       (of),
    .hist_kind_o      (m_axis_tuser),
    .bin_index_o      (bi),
    .bin_count_o      (bc),
    .out_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, bc, bi, of};
endmodule
`default_nettype wire

[rtl/fhm_front.sv]
`default_nettype none
// Input stage and request queue: accepts packets, holds them in a small FIFO.
module fhm_front
  import fhm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire fhm_req_t in_req_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output fhm_req_t      q_req_o
);
  fhm_req_t    mem_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wp_q, rp_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end
endmodule
`default_nettype wire

[rtl/fhm_div1000.sv]
`default_nettype none
// Divide a 32-bit gap by 1000 with a reciprocal multiply: register the operand,
// multiply, then keep the high product bits. done_o marks that the registered product is valid.
module fhm_div1000
  import fhm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);
  // ceil(2^38 / 1000); product >> 38 is the floor quotient for any 32-bit operand
  localparam logic [28:0] Recip = 29'((64'd1 << 38) / UsPerMs + 1);
  logic [31:0] num_q;
  logic [60:0] prod_q;
  logic [1:0]  stg_q;

  assign done_o = (stg_q == 2'd2);
  assign quo_o  = {9'd0, prod_q[60:38]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= 2'd0;
    end else if (start_i) begin
      stg_q <= 2'd1;
    end else if (stg_q == 2'd1) begin
      stg_q <= 2'd2;
    end else begin
      stg_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) num_q <= num_i;
    if (stg_q == 2'd1) prod_q <= 61'(num_q) * 61'(Recip);
  end
endmodule
`default_nettype wire

[rtl/fhm_back.sv]
`default_nettype none
// Flow table update, histogram bump, marker drain and histogram clearing.
module fhm_back
  import fhm_pkg::*;
#(
  parameter int unsigned Flows     = FlowsDef,
  parameter int unsigned MaxBins   = MaxBinsDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [4:0] quant_shift_i,
  input  wire logic [5:0] size_bins_i,
  input  wire logic [5:0] gap_bins_i,
  input  wire logic [7:0] marker_packets_i,
  input  wire logic       q_valid_i,
  output logic            q_ready_o,
  input  wire fhm_req_t   q_req_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_flow_o,
  output logic            hist_kind_o,
  output logic [4:0]      bin_index_o,
  output logic [7:0]      bin_count_o,
  output logic            out_last_o
);
  localparam int unsigned FW  = (Flows > 1) ? $clog2(Flows) : 1;
  localparam int unsigned BW  = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned AW  = FW + BW;
  localparam int unsigned HD  = Flows * MaxBins;
  localparam logic [CountBits-1:0] Top = '1;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRead  = 8'b0000_0010,
    StDiv   = 8'b0000_0100,
    StBinRd = 8'b0000_1000,
    StBinWr = 8'b0001_0000,
    StDrRd  = 8'b0010_0000,
    StDrOut = 8'b0100_0000,
    StClear = 8'b1000_0000
  } st_e;

  st_e st_q, st_d;

  logic [CountBits-1:0] lhist [HD];
  logic [CountBits-1:0] ghist [HD];
  logic [31:0]          ltime [Flows];
  logic [7:0]           pcnt  [Flows];
  logic [Flows-1:0]     seen_q;

  // Fill sweep: clears histograms and counts after reset.
  logic [AW:0] clr_q;
  logic        clr_busy;
  assign clr_busy = (clr_q != (AW+1)'(HD));

  logic [7:0]    slot_raw_q;
  logic [FW-1:0] slot_q;
  logic [15:0]   len_q;
  logic [31:0]   ts_q, lt_rd_q;
  logic [7:0]    cnt_rd_q;
  logic          seen_rd_q;
  logic [BW-1:0] qlen_q, qgap_q;
  logic [CountBits-1:0] lrd_q, grd_q;
  logic [BW:0]   nsize, ngap;
  logic          div_start, div_done;
  logic [31:0]   div_quo;
  logic [7:0]    cnt_new_q;

  // Drain
  logic          dkind_q;
  logic [BW-1:0] didx_q;
  logic [CountBits-1:0] drd_q;
  logic          ovalid_q;

  always_comb begin
    nsize = (size_bins_i == 6'd0) ? (BW+1)'(1) :
            ({26'd0, size_bins_i} > MaxBins) ? (BW+1)'(MaxBins) : (BW+1)'(size_bins_i);
    ngap  = (gap_bins_i == 6'd0) ? (BW+1)'(1) :
            ({26'd0, gap_bins_i} > MaxBins) ? (BW+1)'(MaxBins) : (BW+1)'(gap_bins_i);
  end

  function automatic logic [BW-1:0] clampq(input logic [31:0] v, input logic [4:0] sh,
                                           input logic [BW:0] n);
    logic [31:0] s;
    logic [31:0] lim;
    begin
      s   = v >> sh;
      lim = 32'(n) - 32'd1;
      clampq = (s > lim) ? BW'(lim) : BW'(s);
    end
  endfunction

  assign div_start = (st_q == StRead) && seen_rd_q;

  fhm_div1000 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ts_q - lt_rd_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign q_ready_o = (st_q == StIdle) && !clr_busy;

  logic [BW-1:0] last_idx;
  assign last_idx = dkind_q ? BW'(ngap - (BW+1)'(1)) : BW'(nsize - (BW+1)'(1));

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (q_valid_i && q_ready_o) st_d = StRead;
      StRead:  st_d = seen_rd_q ? StDiv : StBinRd;
      StDiv:   if (div_done) st_d = StBinRd;
      StBinRd: st_d = StBinWr;
      StBinWr: st_d = ({8'd0, cnt_new_q} >= {8'd0, marker_packets_i}) ? StDrRd : StIdle;
      StDrRd:  st_d = StDrOut;
      StDrOut: begin
        if (!ovalid_q || out_ready_i) begin
          if (didx_q == last_idx && dkind_q) st_d = StClear;
          else st_d = StDrRd;
        end
      end
      StClear: if (didx_q == BW'(MaxBins - 1)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic ld_out;
  assign ld_out = (st_q == StDrOut) && (!ovalid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      seen_q   <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (clr_busy) clr_q <= clr_q + (AW+1)'(1);
      if (st_q == StRead) seen_q[slot_q] <= 1'b1;
      if (ld_out) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  logic [AW-1:0] base_addr;
  assign base_addr = {slot_q, BW'(0)};

  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      lhist[clr_q[AW-1:0]] <= '0;
      ghist[clr_q[AW-1:0]] <= '0;
      if (clr_q[BW-1:0] == '0) pcnt[clr_q[AW-1:BW]] <= '0;
    end
    case (st_q)
      StIdle: if (q_valid_i && q_ready_o) begin
        slot_raw_q <= q_req_i.slot;
        slot_q     <= FW'(q_req_i.slot % Flows);
        len_q      <= q_req_i.len;
        ts_q       <= q_req_i.ts;
        lt_rd_q    <= ltime[FW'(q_req_i.slot % Flows)];
        cnt_rd_q   <= pcnt[FW'(q_req_i.slot % Flows)];
        seen_rd_q  <= seen_q[FW'(q_req_i.slot % Flows)];
      end
      StRead: begin
        ltime[slot_q] <= ts_q;
        qlen_q <= clampq({16'd0, len_q}, quant_shift_i, nsize);
        qgap_q <= '0;
        cnt_new_q <= (cnt_rd_q == 8'hFF) ? cnt_rd_q : cnt_rd_q + 8'd1;
      end
      StDiv: if (div_done) qgap_q <= clampq(div_quo, quant_shift_i, ngap);
      StBinRd: begin
        lrd_q <= lhist[{slot_q, qlen_q}];
        grd_q <= ghist[{slot_q, qgap_q}];
        pcnt[slot_q] <= cnt_new_q;
      end
      StBinWr: begin
        lhist[{slot_q, qlen_q}] <= (lrd_q == Top) ? lrd_q : lrd_q + CountBits'(1);
        ghist[{slot_q, qgap_q}] <= (grd_q == Top) ? grd_q : grd_q + CountBits'(1);
        dkind_q <= HistLength;
        didx_q  <= '0;
      end
      StDrRd: drd_q <= dkind_q ? ghist[{slot_q, didx_q}] : lhist[{slot_q, didx_q}];
      StDrOut: if (ld_out) begin
        out_flow_o  <= slot_raw_q;
        hist_kind_o <= dkind_q;
        bin_index_o <= 5'(didx_q);
        bin_count_o <= 8'(drd_q);
        out_last_o  <= dkind_q && (didx_q == last_idx);
        if (didx_q == last_idx) begin
          dkind_q <= HistGap;
          didx_q  <= '0;
        end else begin
          didx_q <= didx_q + BW'(1);
        end
      end
      StClear: begin
        lhist[base_addr | AW'(didx_q)] <= '0;
        ghist[base_addr | AW'(didx_q)] <= '0;
        if (didx_q == '0) pcnt[slot_q] <= '0;
        didx_q <= didx_q + BW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire

[test/tb_flow_histogram_marker_core.sv]
module tb_flow_histogram_marker_core;
  import fhm_pkg::*;

  typedef struct {
    logic [7:0] flow;
    logic       kind;
    logic [4:0] idx;
    logic [7:0] cnt;
    logic       fin;
  } bin_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  flow_histogram_marker_core dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state and register copy
  logic [7:0]  len_hist [256][32];
  logic [7:0]  gap_hist [256][32];
  logic [31:0] last_ts [256];
  logic        seen_q [256];
  logic [7:0]  pkt_cnt [256];
  logic [4:0]  shift_r = 5'd4;
  logic [5:0]  size_r = 6'd32;
  logic [5:0]  gapn_r = 6'd32;
  logic [7:0]  mark_r = 8'd32;

  fhm_req_t pkt_q[$];
  bin_rec_t bins_q[$];
  int       errors = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cycles = 0;
  logic [31:0] ts_run = '0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int bins_used(logic [5:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  task automatic predict_markers(fhm_req_t r);
    int nsize, ngap, slot;
    logic [31:0] gap, qlen, qgap;
    bin_rec_t b;
    slot = r.slot;
    nsize = bins_used(size_r);
    ngap = bins_used(gapn_r);
    gap = seen_q[slot] ? (r.ts - last_ts[slot]) / 1000 : 32'd0;
    last_ts[slot] = r.ts;
    seen_q[slot] = 1'b1;
    qlen = {16'd0, r.len} >> shift_r;
    qgap = gap >> shift_r;
    if (qlen > 32'(nsize - 1)) qlen = 32'(nsize - 1);
    if (qgap > 32'(ngap - 1)) qgap = 32'(ngap - 1);
    if (len_hist[slot][qlen] != 8'hFF) len_hist[slot][qlen]++;
    if (gap_hist[slot][qgap] != 8'hFF) gap_hist[slot][qgap]++;
    if (pkt_cnt[slot] != 8'hFF) pkt_cnt[slot]++;
    if (pkt_cnt[slot] < mark_r) return;
    for (int i = 0; i < nsize; i++) begin
      b = '{r.slot, HistLength, i[4:0], len_hist[slot][i], 1'b0};
      bins_q = {bins_q, b};
    end
    for (int i = 0; i < ngap; i++) begin
      b = '{r.slot, HistGap, i[4:0], gap_hist[slot][i], i == ngap - 1};
      bins_q = {bins_q, b};
    end
    for (int i = 0; i < 32; i++) begin
      len_hist[slot][i] = '0;
      gap_hist[slot][i] = '0;
    end
    pkt_cnt[slot] = '0;
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pkt_q.size() > 0) begin
        fhm_req_t r;
        r = pkt_q.pop_front();
        predict_markers(r);
        s_axis_tdata <= {r.ts, r.len, r.slot};
        s_axis_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bins_q.size() == 0) begin
          $error("unexpected bin: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          bin_rec_t e;
          e = bins_q.pop_front();
          if (m_axis_tdata[7:0] !== e.flow) begin
            $error("out_flow exp %0d got %0d", e.flow, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tuser !== e.kind) begin
            $error("hist_kind exp %0d got %0d", e.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[12:8] !== e.idx) begin
            $error("bin_index exp %0d got %0d", e.idx, m_axis_tdata[12:8]);
            errors++;
          end
          if (m_axis_tdata[20:13] !== e.cnt) begin
            $error("bin_count exp %0d got %0d", e.cnt, m_axis_tdata[20:13]);
            errors++;
          end
          if (m_axis_tlast !== e.fin) begin
            $error("last exp %0d got %0d", e.fin, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegQuantShift: shift_r = val[4:0];
      RegSizeBins:   size_r = val[5:0];
      RegGapBins:    gapn_r = val[5:0];
      default:       mark_r = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int qs, int sb, int gb, int mp);
    write_reg(RegQuantShift, 8'(qs));
    write_reg(RegSizeBins, 8'(sb));
    write_reg(RegGapBins, 8'(gb));
    write_reg(RegMarkerPkts, 8'(mp));
  endtask

  task automatic add_pkt(logic [7:0] slot, logic [15:0] len, logic [31:0] ts);
    fhm_req_t r;
    r.slot = slot;
    r.len = len;
    r.ts = ts;
    pkt_q = {pkt_q, r};
  endtask

  task automatic add_random(int n);
    logic [7:0] pool [4];
    logic [7:0] slot;
    logic [15:0] len;
    pool = '{8'd0, 8'd255, 8'd90, 8'd165};
    for (int i = 0; i < n; i++) begin
      slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pool[$urandom_range(0, 3)];
      len = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
      if ($urandom_range(0, 15) == 0) ts_run = $urandom;
      else ts_run = ts_run + $urandom_range(0, 300000);
      add_pkt(slot, len, ts_run);
    end
  endtask

  // wait out the queues, then let the last packet and clearing walk finish
  task automatic drain();
    while (pkt_q.size() > 0 || s_axis_tvalid || bins_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    for (int f = 0; f < 256; f++) begin
      for (int i = 0; i < 32; i++) begin
        len_hist[f][i] = '0;
        gap_hist[f][i] = '0;
      end
      last_ts[f] = '0;
      seen_q[f] = 1'b0;
      pkt_cnt[f] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, wrap of the time counter, saturating gaps
    set_regs(0, 4, 3, 2);
    add_pkt(8'd0, 16'd0, 32'd0);
    add_pkt(8'd0, 16'hFFFF, 32'd999);
    add_pkt(8'd255, 16'd1, 32'hFFFF_F000);
    add_pkt(8'd255, 16'd2, 32'h0000_1000);
    add_pkt(8'd255, 16'd3, 32'h0000_1000);
    add_pkt(8'd7, 16'hAAAA, 32'hFFFF_FFFF);
    add_pkt(8'd7, 16'h5555, 32'h7FFF_FFFF);
    add_pkt(8'd0, 16'd2, 32'd3999);
    add_pkt(8'd0, 16'd3, 32'd3999);
    add_pkt(8'd128, 16'h8000, 32'h8000_0000);
    add_pkt(8'd128, 16'h7FFF, 32'h0000_0000);
    drain();
    set_regs(31, 0, 33, 0);
    add_pkt(8'd7, 16'hFFFF, 32'h1234_5678);
    add_pkt(8'd1, 16'h0000, 32'h0000_0001);
    add_pkt(8'd1, 16'hFFFF, 32'hFFFF_FFFF);
    drain();

    set_regs(4, 32, 32, 8);
    add_random(70);
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_cycles = 2000;
      end
      drain();
    join
    set_regs(31, 1, 1, 255);
    add_random(25);
    drain();
    set_regs(2, 63, 0, 1);
    add_random(20);
    drain();
    set_regs(5, 8, 16, 3);
    add_random(50);
    drain();
    set_regs(1, 40, 20, 4);
    add_random(50);
    drain();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
rtl/fhm_pkg.sv
rtl/fhm_front.sv
rtl/fhm_div1000.sv
rtl/fhm_back.sv
rtl/flow_histogram_marker_core.sv
test/tb_flow_histogram_marker_core.sv
